### rtl/core/coloc_classify_manders_assert.svh
// assertion macros shared by the coloc_classify_manders rtl
// expects clk and rst in the scope of the including module
`ifndef COLOC_CLASSIFY_MANDERS_ASSERT_SVH
`define COLOC_CLASSIFY_MANDERS_ASSERT_SVH

// same-cycle implication
`define CCM_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccm check failed");

// next-cycle implication
`define CCM_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccm check failed");

`endif

### rtl/core/ccm_pkg.sv
// types and constants of the colocalization classifier
// no dependencies
`timescale 1ns / 1ps

package ccm_pkg;

  localparam int DENSITY_BITS = 24;
  localparam int REGION_BITS  = 8;
  localparam int SUM_BITS     = 40;
  localparam int SUM_EXT      = SUM_BITS + 1;
  localparam int FRAC_BITS    = 16;
  localparam int RATIO_BITS   = FRAC_BITS + 1;
  localparam int STEP_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = DENSITY_BITS;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THR_OWN  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THR_PAR  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CORR_EN  = 2'd2;

  localparam logic [DENSITY_BITS-1:0] THR_RESET = DENSITY_BITS'(4096);

  typedef enum logic [1:0] {
    CLS_BG    = 2'd0,
    CLS_HIGH  = 2'd1,
    CLS_COLOC = 2'd2
  } class_code_t;

  typedef enum logic {
    KIND_CLASS = 1'b0,
    KIND_COEF  = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SETUP,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_CLASS,
    PH_POST
  } phase_t;

  typedef struct packed {
    logic                    close_pre;
    logic [REGION_BITS-1:0]  pre_region;
    logic [SUM_BITS-1:0]     pre_coloc;
    logic [SUM_BITS-1:0]     pre_total;
    class_code_t             cls;
    logic                    close_post;
    logic [REGION_BITS-1:0]  post_region;
    logic [SUM_BITS-1:0]     post_coloc;
    logic [SUM_BITS-1:0]     post_total;
  } ccm_job_t;

endpackage

### rtl/core/ccm_if.sv
// stream interfaces for localization words and result words
// depends on ccm_pkg
`timescale 1ns / 1ps

interface ccm_in_if import ccm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REGION_BITS-1:0]  region_number;
  logic [DENSITY_BITS-1:0] density_own;
  logic [DENSITY_BITS-1:0] density_partner;
  logic                    partner_triangle_valid;
  logic                    partner_triangle_kept;
  logic                    end_of_stream;

  modport source (
    output valid, region_number, density_own, density_partner,
           partner_triangle_valid, partner_triangle_kept, end_of_stream,
    input  ready
  );
  modport sink (
    input  valid, region_number, density_own, density_partner,
           partner_triangle_valid, partner_triangle_kept, end_of_stream,
    output ready
  );
endinterface

interface ccm_out_if import ccm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   result_kind;
  logic [1:0]             class_code;
  logic [REGION_BITS-1:0] closed_region;
  logic [RATIO_BITS-1:0]  manders_ratio;
  logic                   ratio_valid;
  logic                   last_of_run;

  modport source (
    output valid, result_kind, class_code, closed_region, manders_ratio,
           ratio_valid, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, class_code, closed_region, manders_ratio,
           ratio_valid, last_of_run,
    output ready
  );
endinterface

### rtl/core/ccm_front.sv
// front end: config registers, classification, per-region sums
// depends on ccm_pkg and ccm_in_if; pushes jobs into ccm_queue
`timescale 1ns / 1ps

module ccm_front import ccm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  ccm_in_if.sink                   items,
  input  logic                     q_full,
  output logic                     q_push,
  output ccm_job_t                 q_data
);

  logic [DENSITY_BITS-1:0] thr_own;
  logic [DENSITY_BITS-1:0] thr_par;
  logic                    corr_en;

  logic [REGION_BITS-1:0]  open_region;
  logic                    region_open;
  logic [SUM_BITS-1:0]     coloc_sum;
  logic [SUM_BITS-1:0]     total_sum;

  logic                    nz;
  logic                    change;
  logic                    fresh;
  logic [SUM_BITS-1:0]     base_c;
  logic [SUM_BITS-1:0]     base_t;
  logic [SUM_EXT-1:0]      add_c;
  logic [SUM_EXT-1:0]      add_t;
  logic [SUM_BITS-1:0]     coloc_next;
  logic [SUM_BITS-1:0]     total_next;
  logic [REGION_BITS-1:0]  region_next;
  logic                    open_next;
  logic                    close_post;
  class_code_t             cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_own <= THR_RESET;
      thr_par <= THR_RESET;
      corr_en <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THR_OWN: thr_own <= cfg_wdata[DENSITY_BITS-1:0];
        CFG_THR_PAR: thr_par <= cfg_wdata[DENSITY_BITS-1:0];
        CFG_CORR_EN: corr_en <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nz     = items.region_number != '0;
    change = nz && region_open && (items.region_number != open_region);
    fresh  = nz && (change || !region_open);
    base_c = fresh ? '0 : coloc_sum;
    base_t = fresh ? '0 : total_sum;

    cls = CLS_BG;
    if (nz && (items.density_own > thr_own)) begin
      if ((items.density_partner > thr_par) &&
          (!corr_en || (items.partner_triangle_valid && items.partner_triangle_kept)))
        cls = CLS_COLOC;
      else
        cls = CLS_HIGH;
    end

    add_c = {1'b0, base_c} + SUM_EXT'(items.density_own);
    add_t = {1'b0, base_t} + SUM_EXT'(items.density_own);
    coloc_next = base_c;
    total_next = base_t;
    if (cls == CLS_COLOC)
      coloc_next = add_c[SUM_BITS] ? '1 : add_c[SUM_BITS-1:0];
    if (cls != CLS_BG)
      total_next = add_t[SUM_BITS] ? '1 : add_t[SUM_BITS-1:0];

    region_next = nz ? items.region_number : open_region;
    open_next   = nz || region_open;
    close_post  = items.end_of_stream && open_next;

    q_data.close_pre   = change;
    q_data.pre_region  = open_region;
    q_data.pre_coloc   = coloc_sum;
    q_data.pre_total   = total_sum;
    q_data.cls         = cls;
    q_data.close_post  = close_post;
    q_data.post_region = region_next;
    q_data.post_coloc  = coloc_next;
    q_data.post_total  = total_next;
  end

  assign items.ready = !q_full;
  assign q_push      = items.valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_region <= '0;
      region_open <= 1'b0;
      coloc_sum   <= '0;
      total_sum   <= '0;
    end else if (q_push) begin
      open_region <= region_next;
      if (close_post) begin
        region_open <= 1'b0;
        coloc_sum   <= '0;
        total_sum   <= '0;
      end else begin
        region_open <= open_next;
        coloc_sum   <= coloc_next;
        total_sum   <= total_next;
      end
    end
  end

endmodule

### rtl/core/ccm_queue.sv
// two-word job queue between front and back end
// depends on ccm_pkg
`timescale 1ns / 1ps

module ccm_queue import ccm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ccm_job_t push_data,
  input  logic     pop,
  output ccm_job_t pop_data,
  output logic     full,
  output logic     empty
);

  ccm_job_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= !wr_ptr;
      if (pop)
        rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/ccm_back.sv
// back end: result sequencing, radix-2 ratio divider, output register
// depends on ccm_pkg and ccm_out_if; pops jobs from ccm_queue
`timescale 1ns / 1ps
`include "coloc_classify_manders_assert.svh"

module ccm_back import ccm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  ccm_job_t q_data,
  output logic     q_pop,
  ccm_out_if.source results
);

  bk_state_t state, state_next;
  phase_t    phase;
  ccm_job_t  job;

  logic [SUM_BITS-1:0]   r;
  logic [SUM_BITS-1:0]   den;
  logic [FRAC_BITS-1:0]  q;
  logic [STEP_BITS-1:0]  cnt;
  logic [RATIO_BITS-1:0] res_ratio;
  logic                  res_valid;

  logic                   ph_coef;
  logic [SUM_BITS-1:0]    sel_c;
  logic [SUM_BITS-1:0]    sel_t;
  logic [REGION_BITS-1:0] sel_region;
  logic                   need_div;
  logic                   last;
  logic                   out_free;
  logic                   emit;
  logic [SUM_EXT-1:0]     r2;
  logic [SUM_EXT-1:0]     r_step;
  logic                   ge;
  logic [FRAC_BITS-1:0]   q_step;

  always_comb begin
    ph_coef    = phase != PH_CLASS;
    sel_c      = (phase == PH_PRE) ? job.pre_coloc  : job.post_coloc;
    sel_t      = (phase == PH_PRE) ? job.pre_total  : job.post_total;
    sel_region = (phase == PH_PRE) ? job.pre_region : job.post_region;
    need_div   = (sel_t != '0) && (sel_c < sel_t);
    last       = (phase == PH_POST) || ((phase == PH_CLASS) && !job.close_post);
    out_free   = !results.valid || results.ready;
    r2         = {r, 1'b0};
    ge         = r2 >= {1'b0, den};
    r_step     = ge ? (r2 - {1'b0, den}) : r2;
    q_step     = {q[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= BK_IDLE;
    else
      state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_SETUP;
        end
      end
      BK_SETUP: begin
        state_next = (ph_coef && need_div) ? BK_DIV : BK_EMIT;
      end
      BK_DIV: begin
        if (cnt == '1)
          state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = last ? BK_IDLE : BK_SETUP;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CLASS;
    end else if (q_pop) begin
      phase <= q_data.close_pre ? PH_PRE : PH_CLASS;
    end else if (emit) begin
      if (phase == PH_PRE)
        phase <= PH_CLASS;
      else if (phase == PH_CLASS)
        phase <= PH_POST;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)
      job <= q_data;
    if (state == BK_SETUP) begin
      r         <= sel_c;
      den       <= sel_t;
      q         <= '0;
      cnt       <= '0;
      res_ratio <= (sel_t == '0) ? '0 : RATIO_ONE;
      res_valid <= sel_t != '0;
    end else if (state == BK_DIV) begin
      r   <= r_step[SUM_BITS-1:0];
      q   <= q_step;
      cnt <= cnt + 1'b1;
      if (cnt == '1)
        res_ratio <= {1'b0, q_step};
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      results.valid <= 1'b0;
    else if (emit)
      results.valid <= 1'b1;
    else if (results.ready)
      results.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.last_of_run <= last;
      if (ph_coef) begin
        results.result_kind   <= KIND_COEF;
        results.class_code    <= CLS_BG;
        results.closed_region <= sel_region;
        results.manders_ratio <= res_ratio;
        results.ratio_valid   <= res_valid;
      end else begin
        results.result_kind   <= KIND_CLASS;
        results.class_code    <= job.cls;
        results.closed_region <= '0;
        results.manders_ratio <= '0;
        results.ratio_valid   <= 1'b0;
      end
    end
  end

  `CCM_CHK_IMP(a_div_bounds, state == BK_DIV, (den != '0) && (r < den))
  `CCM_CHK_IMP(a_ratio_range, emit && ph_coef, res_ratio <= RATIO_ONE)
  `CCM_CHK_IMP(a_invalid_zero, emit && ph_coef && !res_valid, res_ratio == '0)

endmodule

### rtl/core/coloc_classify_manders.sv
// Colocalization classifier: takes one localization word per accepted
// transfer, gives its class and, whenever a region closes, the Manders ratio
// of that region. The front end takes a word every cycle while its two-word
// job queue has room; the back end pops one job at a time and emits the ratio
// of a region closed by a change of region number, then the class word, then
// the ratio of a region closed by end of stream, dividing when it is below one.
// Depends on ccm_pkg, ccm_if, ccm_front, ccm_queue and ccm_back.
`timescale 1ns / 1ps

module coloc_classify_manders import ccm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  ccm_in_if.sink                   items,
  ccm_out_if.source                results
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  ccm_job_t push_data;
  ccm_job_t pop_data;

  ccm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .items     (items),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  ccm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ccm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

### test/tb_top.sv
// self-checking bench for coloc_classify_manders: directed table and random region runs,
// each word checked against an in-bench classifier
// depends on ccm_pkg, ccm_if and the block rtl
`timescale 1ns / 1ps

module tb_top;
  import ccm_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;
  localparam int NO_CHECK = -1;
  localparam int RUN_WORDS = 24;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam logic [DENSITY_BITS-1:0] DENS_MAX = '1;

  typedef struct packed {
    logic [REGION_BITS-1:0]  region;
    logic [DENSITY_BITS-1:0] own;
    logic [DENSITY_BITS-1:0] partner;
    bit                      tri_valid;
    bit                      tri_kept;
    bit                      eos;
  } loc_word_t;

  typedef struct packed {
    result_kind_t           kind;
    class_code_t            cls;
    logic [REGION_BITS-1:0] region;
    logic [RATIO_BITS-1:0]  ratio;
    bit                     rvalid;
    bit                     last;
  } res_word_t;

  typedef enum bit {ROW_WORD, ROW_CONFIG} row_op_t;

  // config rows carry threshold_own, threshold_partner and correction in own,
  // partner and tri_valid
  typedef struct packed {
    row_op_t   op;
    loc_word_t w;
    int        cls_t;
    int        ratio_t;
    bit        rv_t;
  } row_t;

  localparam int N_ROWS = 25;

  row_t script [N_ROWS] = '{
    '{ROW_WORD, '{8'd0, DENS_MAX, DENS_MAX, 1, 1, 0}, CLS_BG, NO_CHECK, 0},
    '{ROW_WORD, '{8'd0, 24'd0, 24'd0, 0, 0, 1}, CLS_BG, NO_CHECK, 0},
    '{ROW_WORD, '{8'd1, 24'd4096, DENS_MAX, 1, 1, 0}, CLS_BG, NO_CHECK, 0},
    '{ROW_WORD, '{8'd1, 24'd4097, 24'd4096, 1, 1, 0}, CLS_HIGH, NO_CHECK, 0},
    '{ROW_WORD, '{8'd1, 24'd4097, 24'd4097, 1, 1, 0}, CLS_COLOC, NO_CHECK, 0},
    '{ROW_WORD, '{8'd1, DENS_MAX, DENS_MAX, 1, 0, 0}, CLS_HIGH, NO_CHECK, 0},
    '{ROW_WORD, '{8'd1, DENS_MAX, DENS_MAX, 0, 1, 0}, CLS_HIGH, NO_CHECK, 0},
    '{ROW_WORD, '{8'd3, 24'd0, 24'd0, 0, 0, 0}, CLS_BG, NO_CHECK, 0},
    '{ROW_WORD, '{8'd3, 24'd0, 24'd0, 0, 0, 1}, CLS_BG, 0, 0},
    '{ROW_WORD, '{8'd5, DENS_MAX, DENS_MAX, 1, 1, 0}, CLS_COLOC, NO_CHECK, 0},
    '{ROW_WORD, '{8'd2, DENS_MAX, DENS_MAX, 1, 1, 0}, CLS_COLOC, RATIO_ONE, 1},
    '{ROW_WORD, '{8'd0, DENS_MAX, DENS_MAX, 1, 1, 1}, CLS_BG, RATIO_ONE, 1},
    '{ROW_WORD, '{8'd200, 24'd5000, 24'd0, 1, 1, 0}, CLS_HIGH, NO_CHECK, 0},
    '{ROW_WORD, '{8'd255, DENS_MAX, DENS_MAX, 1, 1, 0}, CLS_COLOC, 0, 1},
    '{ROW_WORD, '{8'd255, 24'd1, DENS_MAX, 0, 0, 1}, CLS_BG, RATIO_ONE, 1},
    '{ROW_WORD, '{8'd7, 24'd4097, DENS_MAX, 1, 1, 1}, CLS_COLOC, RATIO_ONE, 1},
    '{ROW_WORD, '{8'd9, DENS_MAX, 24'd0, 1, 1, 0}, CLS_HIGH, NO_CHECK, 0},
    '{ROW_WORD, '{8'd9, 24'h800000, 24'h800000, 1, 1, 0}, CLS_COLOC, NO_CHECK, 0},
    '{ROW_WORD, '{8'd9, 24'h123456, 24'habcdef, 1, 1, 1}, NO_CHECK, NO_CHECK, 0},
    '{ROW_CONFIG, '{8'd0, 24'd0, 24'd0, 0, 0, 0}, NO_CHECK, NO_CHECK, 0},
    '{ROW_WORD, '{8'd4, 24'd1, 24'd1, 0, 0, 0}, CLS_COLOC, NO_CHECK, 0},
    '{ROW_WORD, '{8'd4, 24'd0, DENS_MAX, 1, 1, 0}, CLS_BG, NO_CHECK, 0},
    '{ROW_WORD, '{8'd4, DENS_MAX, 24'd0, 1, 1, 1}, CLS_HIGH, NO_CHECK, 0},
    '{ROW_CONFIG, '{8'd0, DENS_MAX, DENS_MAX, 1, 0, 0}, NO_CHECK, NO_CHECK, 0},
    '{ROW_WORD, '{8'd6, DENS_MAX, DENS_MAX, 1, 1, 1}, CLS_BG, 0, 0}
  };

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  ccm_in_if  loc_ch ();
  ccm_out_if res_ch ();

  coloc_classify_manders dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .items     (loc_ch),
    .results   (res_ch)
  );

  // classifier state
  logic [DENSITY_BITS-1:0] thr_own;
  logic [DENSITY_BITS-1:0] thr_par;
  bit                      corr_en;
  logic [REGION_BITS-1:0]  cur_region;
  bit                      region_live;
  logic [SUM_BITS-1:0]     coloc_acc;
  logic [SUM_BITS-1:0]     total_acc;

  res_word_t class_ratio_words [$];
  res_word_t step_words [$];

  int bad_words;
  int cycle_count;
  bit tx_busy;
  bit rx_busy;
  bit rx_hold_req;
  int rx_hold;
  int rx_stall;
  int gen_region;
  int run_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [SUM_BITS-1:0] sum_sat(input logic [SUM_BITS-1:0] a,
                                                  input logic [DENSITY_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + b;
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

  function automatic logic [RATIO_BITS-1:0] manders_q16(input logic [SUM_BITS-1:0] num,
                                                        input logic [SUM_BITS-1:0] den);
    logic [SUM_BITS+FRAC_BITS-1:0] scaled;
    if (num >= den) return RATIO_ONE;
    scaled = {num, {FRAC_BITS{1'b0}}};
    return RATIO_BITS'(scaled / den);
  endfunction

  function automatic void close_region_word();
    res_word_t r;
    r = '{KIND_COEF, CLS_BG, cur_region, '0, 1'b0, 1'b0};
    if (total_acc != 0) begin
      r.ratio = manders_q16(coloc_acc, total_acc);
      r.rvalid = 1'b1;
    end
    step_words.insert(step_words.size(), r);
    region_live = 1'b0;
    coloc_acc = '0;
    total_acc = '0;
  endfunction

  function automatic void classify_loc(input loc_word_t w);
    class_code_t cls;
    res_word_t cw;
    cls = CLS_BG;
    step_words.delete();
    if (w.region != 0) begin
      if (region_live && w.region != cur_region) close_region_word();
      if (!region_live) begin
        region_live = 1'b1;
        cur_region = w.region;
        coloc_acc = '0;
        total_acc = '0;
      end
      if (w.own > thr_own) begin
        cls = (w.partner > thr_par && (!corr_en || (w.tri_valid && w.tri_kept))) ?
              CLS_COLOC : CLS_HIGH;
      end
      if (cls != CLS_BG) total_acc = sum_sat(total_acc, w.own);
      if (cls == CLS_COLOC) coloc_acc = sum_sat(coloc_acc, w.own);
    end
    cw = '{KIND_CLASS, cls, '0, '0, 1'b0, 1'b0};
    step_words.insert(step_words.size(), cw);
    if (w.eos && region_live) close_region_word();
    step_words[step_words.size()-1].last = 1'b1;
  endfunction

  function automatic void log_accepted(input loc_word_t w, input int cls_t, input int ratio_t,
                                       input bit rv_t);
    bit typed_done;
    typed_done = 1'b0;
    classify_loc(w);
    foreach (step_words[i]) begin
      if (step_words[i].kind == KIND_CLASS && cls_t != NO_CHECK)
        step_words[i].cls = class_code_t'(cls_t);
      if (step_words[i].kind == KIND_COEF && ratio_t != NO_CHECK && !typed_done) begin
        step_words[i].ratio = RATIO_BITS'(ratio_t);
        step_words[i].rvalid = rv_t;
        typed_done = 1'b1;
      end
      class_ratio_words.insert(class_ratio_words.size(), step_words[i]);
    end
  endfunction

  function automatic logic [DENSITY_BITS-1:0] pick_density(input logic [DENSITY_BITS-1:0] thr);
    int off;
    case ($urandom_range(0, 3))
      0: begin
        off = $urandom_range(0, 2);
        if (off == 0 && thr != 0) return thr - 1'b1;
        if (off == 2 && thr != DENS_MAX) return thr + 1'b1;
        return thr;
      end
      1: return DENSITY_BITS'($urandom);
      2: return DENSITY_BITS'($urandom_range(0, 8191));
      default: return $urandom_range(0, 1) ? DENS_MAX : '0;
    endcase
  endfunction

  task automatic send_word(input loc_word_t w, input int cls_t, input int ratio_t,
                           input bit rv_t);
    int gap;
    gap = tx_busy ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      loc_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    loc_ch.valid                  <= 1'b1;
    loc_ch.region_number          <= w.region;
    loc_ch.density_own            <= w.own;
    loc_ch.density_partner        <= w.partner;
    loc_ch.partner_triangle_valid <= w.tri_valid;
    loc_ch.partner_triangle_kept  <= w.tri_kept;
    loc_ch.end_of_stream          <= w.eos;
    @(posedge clk);
    while (!loc_ch.ready) @(posedge clk);
    log_accepted(w, cls_t, ratio_t, rv_t);
  endtask

  task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_THR_OWN: thr_own = data;
      CFG_THR_PAR: thr_par = data;
      CFG_CORR_EN: corr_en = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [DENSITY_BITS-1:0] own_t,
                              input logic [DENSITY_BITS-1:0] par_t, input bit corr);
    logic [CFG_DATA_BITS-1:0] corr_data;
    corr_data = CFG_DATA_BITS'($urandom);
    corr_data[0] = corr;
    loc_ch.valid <= 1'b0;
    while (class_ratio_words.size() != 0) @(posedge clk);
    reg_write(CFG_THR_OWN, own_t);
    reg_write(CFG_THR_PAR, par_t);
    reg_write(CFG_CORR_EN, corr_data);
    reg_write(CFG_SPARE, CFG_DATA_BITS'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // ascending region runs with random content, some region zero and jumps
  task automatic send_random_words(input int count);
    loc_word_t w;
    int pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        w.region = '0;
      end else begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) gen_region = $urandom_range(1, 255);
          else gen_region = gen_region + $urandom_range(1, 3);
          if (gen_region > 255) gen_region = gen_region - 255;
          run_left = $urandom_range(1, 6);
        end
        run_left--;
        w.region = REGION_BITS'(gen_region);
      end
      w.own = pick_density(thr_own);
      w.partner = pick_density(thr_par);
      w.tri_valid = ($urandom_range(0, 3) != 0);
      w.tri_kept = ($urandom_range(0, 3) != 0);
      w.eos = (k == count - 1) || ($urandom_range(0, 19) == 0);
      send_word(w, NO_CHECK, NO_CHECK, 1'b0);
    end
  endtask

  task automatic check_result();
    res_word_t e;
    if (class_ratio_words.size() == 0) begin
      bad_words++;
      if (bad_words <= 10)
        $display("unexpected result word: kind %0d class %0d region %0d ratio %0h rv %0d",
                 res_ch.result_kind, res_ch.class_code, res_ch.closed_region,
                 res_ch.manders_ratio, res_ch.ratio_valid);
    end else begin
      e = class_ratio_words.pop_front();
      if (res_ch.result_kind !== e.kind || res_ch.class_code !== e.cls ||
          res_ch.closed_region !== e.region || res_ch.manders_ratio !== e.ratio ||
          res_ch.ratio_valid !== e.rvalid || res_ch.last_of_run !== e.last) begin
        bad_words++;
        if (bad_words <= 10)
          $display("result mismatch: exp %0d/%0d/%0d/%0h/%0d/%0d got %0d/%0d/%0d/%0h/%0d/%0d",
                   e.kind, e.cls, e.region, e.ratio, e.rvalid, e.last,
                   res_ch.result_kind, res_ch.class_code, res_ch.closed_region,
                   res_ch.manders_ratio, res_ch.ratio_valid, res_ch.last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_stall = 0;
      rx_hold = 0;
    end else begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold = HOLD_CYCLES;
      end
      if (res_ch.valid && res_ch.ready) begin
        check_result();
        rx_stall = rx_busy ? $urandom_range(0, 7) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        res_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_THR_OWN;
    cfg_wdata = '0;
    loc_ch.valid = 1'b0;
    loc_ch.region_number = '0;
    loc_ch.density_own = '0;
    loc_ch.density_partner = '0;
    loc_ch.partner_triangle_valid = 1'b0;
    loc_ch.partner_triangle_kept = 1'b0;
    loc_ch.end_of_stream = 1'b0;
    thr_own = THR_RESET;
    thr_par = THR_RESET;
    corr_en = 1'b1;
    cur_region = '0;
    region_live = 1'b0;
    coloc_acc = '0;
    total_acc = '0;
    bad_words = 0;
    tx_busy = 1'b1;
    rx_busy = 1'b1;
    rx_hold_req = 1'b0;
    gen_region = 1;
    run_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].op == ROW_CONFIG)
        apply_config(script[i].w.own, script[i].w.partner, script[i].w.tri_valid);
      else
        send_word(script[i].w, script[i].cls_t, script[i].ratio_t, script[i].rv_t);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_config(THR_RESET, THR_RESET, 1'b1);
        1: apply_config('0, '0, 1'b0);
        2: apply_config(DENS_MAX, DENS_MAX, 1'b1);
        3: apply_config(DENSITY_BITS'($urandom), DENSITY_BITS'($urandom), 1'b1);
        default: apply_config(DENSITY_BITS'($urandom_range(0, 20000)),
                              DENSITY_BITS'($urandom_range(0, 20000)),
                              1'($urandom_range(0, 1)));
      endcase
      tx_busy = ($urandom_range(0, 3) != 0);
      rx_busy = ($urandom_range(0, 3) != 0);
      // long output backpressure while words keep coming
      if (p == 3) begin
        tx_busy = 1'b0;
        rx_hold_req = 1'b1;
      end
      send_random_words(RUN_WORDS);
    end

    loc_ch.valid <= 1'b0;
    while (class_ratio_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
